// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the port-level checker.
// Each macro expects a clock named i_clk and an active-low reset i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AST_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/hcrt_pkg.sv =====
// Package for the hop-count route table: item kinds, register map, constants, and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package hcrt_pkg;

    localparam int NODES_DEF = 16;

    localparam int HOPS_W  = 5;
    localparam int RELAY_W = 4;

    localparam logic [HOPS_W-1:0]  NO_ROUTE  = 5'd31;
    localparam logic [RELAY_W-1:0] NO_RELAY  = 4'hF;
    localparam logic [7:0]         NONE_BYTE = 8'hFF;

    localparam logic [2:0] K_MERGE  = 3'd0;
    localparam logic [2:0] K_LOOKUP = 3'd1;
    localparam logic [2:0] K_REMOVE = 3'd2;
    localparam logic [2:0] K_ROTATE = 3'd3;
    localparam logic [2:0] K_EXPORT = 3'd4;

    // register index, taken from paddr[2]
    localparam logic REG_OWN_ID    = 1'b0;
    localparam logic REG_MIN_LEVEL = 1'b1;

    typedef struct packed {
        logic load_item;    // capture input beat, clear export counter
        logic apply;        // perform merge / remove / rotate of the held item
        logic emit_lookup;  // load output register with lookup answer
        logic emit_export;  // load output register with one export entry
    } t_dp_cmd;

    typedef struct packed {
        logic is_lookup;
        logic is_export;
        logic cnt_last;     // export counter on final entry
    } t_dp_stat;

endpackage

// ===== hw/rtl/hcrt_ctrl.sv =====
// Controller for the hop-count route table: item sequencing and output valid.
// Depends on hcrt_pkg.
`timescale 1ns / 1ps

module hcrt_ctrl
    import hcrt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  logic     i_out_ready,
    output logic     o_out_valid,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_EXPORT = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;
    logic       emit;

    assign out_free = !r_out_valid || i_out_ready;
    assign emit     = o_cmd.emit_lookup || o_cmd.emit_export;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.is_lookup) begin
                    if (out_free) begin
                        o_cmd.emit_lookup = 1'b1;
                        n_state           = S_IDLE;
                    end
                end else if (i_stat.is_export) begin
                    n_state = S_EXPORT;
                end else begin
                    o_cmd.apply = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_EXPORT: begin
                if (out_free) begin
                    o_cmd.emit_export = 1'b1;
                    if (i_stat.cnt_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== hw/rtl/hcrt_dp.sv =====
// Datapath for the hop-count route table: item register, both route rounds,
// export counter and output payload register. Depends on hcrt_pkg.
`timescale 1ns / 1ps

module hcrt_dp
    import hcrt_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_dp_cmd      i_cmd,
    output t_dp_stat     o_stat,
    input  logic [4:0]   i_own_id,
    input  logic [7:0]   i_min_level,
    input  logic [2:0]   i_kind,
    input  logic [4:0]   i_target_id,
    input  logic [4:0]   i_sender_id,
    input  logic [7:0]   i_rx_level,
    input  logic [3:0]   i_entry_index,
    input  logic [7:0]   i_entry_byte,
    input  logic         i_entry_last,
    output logic [7:0]   o_next_hop_id,
    output logic         o_route_found,
    output logic [3:0]   o_out_relay,
    output logic [3:0]   o_out_hops,
    output logic [7:0]   o_out_byte,
    output logic         o_last
);

    localparam int IW = $clog2(NODES);

    // held item
    logic [2:0] r_kind;
    logic [4:0] r_target;
    logic [4:0] r_sender;
    logic [7:0] r_level;
    logic [3:0] r_idx;
    logic [7:0] r_ebyte;
    logic       r_elast;

    logic [HOPS_W-1:0]  r_cur_hops  [NODES];
    logic [RELAY_W-1:0] r_cur_relay [NODES];
    logic [HOPS_W-1:0]  r_prev_hops [NODES];
    logic [RELAY_W-1:0] r_prev_relay[NODES];

    logic [IW-1:0] r_cnt;

    logic [4:0]         own_idx;
    logic [4:0]         tgt5;
    logic [4:0]         sidx5;
    logic               tgt_ok;
    logic               snd_ok;
    logic               lvl_ok;
    logic               idx_ok;
    logic               ent_ok;
    logic [HOPS_W-1:0]  new_hops;
    logic [IW-1:0]      rd_addr;
    logic [IW-1:0]      tgt_a;
    logic [IW-1:0]      idx_a;
    logic [IW-1:0]      sidx_a;
    logic [HOPS_W-1:0]  rd_cur_h;
    logic [RELAY_W-1:0] rd_cur_r;
    logic [HOPS_W-1:0]  rd_prev_h;
    logic [RELAY_W-1:0] rd_prev_r;
    logic [7:0]         lk_hop;
    logic               lk_found;
    logic [HOPS_W-1:0]  ex_h;
    logic [RELAY_W-1:0] ex_r;
    logic               do_merge;

    // own_id 0 wraps to 31 and so matches no relay nibble or index
    assign own_idx = i_own_id - 5'd1;
    assign tgt5    = r_target - 5'd1;
    assign sidx5   = r_sender - 5'd1;
    assign tgt_a   = tgt5[IW-1:0];
    assign idx_a   = r_idx[IW-1:0];
    assign sidx_a  = sidx5[IW-1:0];

    assign tgt_ok = (r_target != 5'd0) && (r_target <= 5'(NODES));
    assign snd_ok = (r_sender != 5'd0) && (r_sender <= 5'(NODES));
    assign lvl_ok = r_level > i_min_level;
    assign idx_ok = {1'b0, r_idx} < 5'(NODES);
    assign ent_ok = idx_ok && (r_ebyte != NONE_BYTE)
                    && ({1'b0, r_ebyte[3:0]} != own_idx)
                    && ({1'b0, r_idx} != own_idx);
    assign new_hops = {1'b0, r_ebyte[7:4]} + 5'd1;

    // one read port on the round tables
    always_comb begin
        case (r_kind)
            K_EXPORT: rd_addr = r_cnt;
            K_LOOKUP: rd_addr = tgt_a;
            default:  rd_addr = idx_a;
        endcase
    end

    assign rd_cur_h  = r_cur_hops[rd_addr];
    assign rd_cur_r  = r_cur_relay[rd_addr];
    assign rd_prev_h = r_prev_hops[rd_addr];
    assign rd_prev_r = r_prev_relay[rd_addr];

    always_comb begin
        if (!tgt_ok) begin
            lk_hop   = NONE_BYTE;
            lk_found = 1'b0;
        end else if (rd_cur_h != NO_ROUTE) begin
            lk_hop   = 8'({4'd0, rd_cur_r}) + 8'd1;
            lk_found = 1'b1;
        end else if (rd_prev_h != NO_ROUTE) begin
            lk_hop   = 8'({4'd0, rd_prev_r}) + 8'd1;
            lk_found = 1'b1;
        end else begin
            lk_hop   = NONE_BYTE;
            lk_found = 1'b0;
        end
    end

    assign ex_h = (rd_cur_h != NO_ROUTE) ? rd_cur_h : rd_prev_h;
    assign ex_r = (rd_cur_h != NO_ROUTE) ? rd_cur_r : rd_prev_r;

    assign do_merge = i_cmd.apply && (r_kind == K_MERGE) && snd_ok && lvl_ok;

    assign o_stat.is_lookup = (r_kind == K_LOOKUP);
    assign o_stat.is_export = (r_kind == K_EXPORT);
    assign o_stat.cnt_last  = (r_cnt == IW'(NODES - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_kind   <= i_kind;
            r_target <= i_target_id;
            r_sender <= i_sender_id;
            r_level  <= i_rx_level;
            r_idx    <= i_entry_index;
            r_ebyte  <= i_entry_byte;
            r_elast  <= i_entry_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load_item) begin
            r_cnt <= '0;
        end else if (i_cmd.emit_export) begin
            r_cnt <= r_cnt + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NODES; i++) begin
                r_cur_hops[i]   <= NO_ROUTE;
                r_cur_relay[i]  <= NO_RELAY;
                r_prev_hops[i]  <= NO_ROUTE;
                r_prev_relay[i] <= NO_RELAY;
            end
        end else if (i_cmd.apply) begin
            if (do_merge) begin
                if (ent_ok && (rd_cur_h >= new_hops)) begin
                    r_cur_hops[idx_a]  <= new_hops;
                    r_cur_relay[idx_a] <= sidx5[RELAY_W-1:0];
                end
                // neighbour itself, wins over the entry write above
                if (r_elast) begin
                    r_cur_hops[sidx_a]  <= 5'd1;
                    r_cur_relay[sidx_a] <= sidx5[RELAY_W-1:0];
                end
            end
            if ((r_kind == K_REMOVE) && tgt_ok) begin
                r_cur_hops[tgt_a]   <= NO_ROUTE;
                r_cur_relay[tgt_a]  <= NO_RELAY;
                r_prev_hops[tgt_a]  <= NO_ROUTE;
                r_prev_relay[tgt_a] <= NO_RELAY;
            end
            if (r_kind == K_ROTATE) begin
                for (int i = 0; i < NODES; i++) begin
                    r_prev_hops[i]  <= r_cur_hops[i];
                    r_prev_relay[i] <= r_cur_relay[i];
                    r_cur_hops[i]   <= NO_ROUTE;
                    r_cur_relay[i]  <= NO_RELAY;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_lookup) begin
            o_next_hop_id <= lk_hop;
            o_route_found <= lk_found;
            o_out_relay   <= 4'd0;
            o_out_hops    <= 4'd0;
            o_out_byte    <= 8'd0;
            o_last        <= 1'b1;
        end else if (i_cmd.emit_export) begin
            o_next_hop_id <= 8'd0;
            o_route_found <= 1'b0;
            o_out_relay   <= ex_r;
            o_out_hops    <= ex_h[3:0];
            o_out_byte    <= {ex_h[3:0], ex_r};
            o_last        <= o_stat.cnt_last;
        end
    end

endmodule

// ===== hw/rtl/hop_count_route_table.sv =====
// Top level of the hop-count route table: APB register file, controller and datapath.
// Depends on hcrt_pkg, hcrt_ctrl, hcrt_dp.
//
//   channel   dir   handshake            payload
//   item      in    i_valid / o_ready    i_kind .. i_entry_last
//   result    out   o_valid / i_ready    o_next_hop_id .. o_last
//   config    in    psel/penable/pready  paddr, pwdata, pwrite -> prdata
//
// Merge, remove, rotate: capture, then table update.
// Lookup: capture, then the answer, once the output register is free to take it.
// Export: capture, a decode step, then the NODES entries, one per cycle off the
// single table read port while the output register is free to take them.
// Reset clears both rounds to no route at once; no clearing pass.
// A stalled result holds in the output register; the next item is taken meanwhile.
`timescale 1ns / 1ps

module hop_count_route_table
    import hcrt_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_kind,
    input  logic [4:0]  i_target_id,
    input  logic [4:0]  i_sender_id,
    input  logic [7:0]  i_rx_level,
    input  logic [3:0]  i_entry_index,
    input  logic [7:0]  i_entry_byte,
    input  logic        i_entry_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_next_hop_id,
    output logic        o_route_found,
    output logic [3:0]  o_out_relay,
    output logic [3:0]  o_out_hops,
    output logic [7:0]  o_out_byte,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [4:0] r_own_id;
    logic [7:0] r_min_level;
    logic       cfg_wr;
    t_dp_cmd    cmd;
    t_dp_stat   stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id    <= 5'd1;
            r_min_level <= 8'd0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_OWN_ID:    r_own_id    <= pwdata[4:0];
                REG_MIN_LEVEL: r_min_level <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_OWN_ID:    prdata = {27'd0, r_own_id};
            REG_MIN_LEVEL: prdata = {24'd0, r_min_level};
            default:       prdata = 32'd0;
        endcase
    end

    hcrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_out_ready (i_ready),
        .o_out_valid (o_valid),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    hcrt_dp #(
        .NODES (NODES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_own_id      (r_own_id),
        .i_min_level   (r_min_level),
        .i_kind        (i_kind),
        .i_target_id   (i_target_id),
        .i_sender_id   (i_sender_id),
        .i_rx_level    (i_rx_level),
        .i_entry_index (i_entry_index),
        .i_entry_byte  (i_entry_byte),
        .i_entry_last  (i_entry_last),
        .o_next_hop_id (o_next_hop_id),
        .o_route_found (o_route_found),
        .o_out_relay   (o_out_relay),
        .o_out_hops    (o_out_hops),
        .o_out_byte    (o_out_byte),
        .o_last        (o_last)
    );

endmodule

// ===== hw/rtl/hcrt_chk.sv =====
// Port-level checker for the hop-count route table, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hcrt_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_next_hop_id,
    input logic       o_route_found,
    input logic [3:0] o_out_relay,
    input logic [3:0] o_out_hops,
    input logic [7:0] o_out_byte,
    input logic       o_last
);

    // a stalled result beat stays valid and keeps its byte and next-hop payload
    `AST_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_out_byte) && $stable(o_next_hop_id), "result changed while stalled")

    // no item is taken in the cycle right after a capture
    `AST_NEXT(a_one_at_a_time, i_valid && o_ready, !o_ready, "item taken on back-to-back cycles")

    // found route never reports the no-route code and is marked last
    `AST_IMPLIES(a_found_id, o_valid && o_route_found, o_next_hop_id != 8'hFF && o_last, "found route with bad next hop")

    // export beats carry the packed byte, lookup beats leave it zero
    `AST_IMPLIES(a_byte_pack, o_valid, o_out_byte == {o_out_hops, o_out_relay}, "export byte not packed")

    `AST_IMPLIES(a_lookup_zero, o_valid && o_next_hop_id != 8'd0, o_out_byte == 8'd0, "lookup beat carries export data")

endmodule

bind hop_count_route_table hcrt_chk u_chk (.*);
